// ----- design/lspp_pkg.sv -----
// Shared types and constants for the lidar scan packet parser.
// No dependencies.
`timescale 1ns / 1ps

package lspp_pkg;

    localparam int TABLE_DEPTH = 360;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int DIST_W      = 16;
    localparam int ARAW_W      = 15;
    localparam int QUAL_W      = 6;
    localparam int DEG_W       = 9;

    // Rounding offset for Q6 degrees (half a degree)
    localparam int ANGLE_ROUND = 32;

    typedef enum logic {
        MODE_BYTE = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_PACKET = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic [ARAW_W-1:0] angle_raw;
        logic [DEG_W-1:0]  angle_degree;
        logic [DIST_W-1:0] distance_raw;
    } pkt_t;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [DIST_W-1:0] data;
    } tbl_wr_t;

endpackage

// ----- design/lspp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lspp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 360
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lspp_parser.sv -----
// Byte framing and field decode for 5-byte measurement packets.
// Depends on lspp_pkg.
`timescale 1ns / 1ps

module lspp_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          scan_enable,
    input  logic          feed,
    input  logic [7:0]    data_byte,
    output logic          pkt_valid,
    output lspp_pkg::pkt_t pkt
);
    import lspp_pkg::*;

    logic [7:0] bytes_reg [4];
    logic [7:0] bytes_next [4];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       step;
    logic       start_ok;
    logic [ARAW_W:0]  angle_sum;
    logic [DEG_W:0]   deg_full;
    logic [ARAW_W-1:0] araw;

    assign step      = feed && scan_enable;
    assign pkt_valid = step && (cnt_reg == 3'd4);

    // check bit in byte 1, start flag and its inverse in byte 0
    assign start_ok = data_byte[0] && (bytes_reg[0][0] ^ bytes_reg[0][1]);

    assign araw      = {bytes_reg[2], bytes_reg[1][7:1]};
    assign angle_sum = {1'b0, araw} + (ARAW_W+1)'(ANGLE_ROUND);
    assign deg_full  = angle_sum[ARAW_W:6];

    always_comb begin
        pkt.quality   = bytes_reg[0][7:2];
        pkt.angle_raw = araw;
        if (deg_full >= (DEG_W+1)'(TABLE_DEPTH)) begin
            pkt.angle_degree = DEG_W'(deg_full - (DEG_W+1)'(TABLE_DEPTH));
        end else begin
            pkt.angle_degree = deg_full[DEG_W-1:0];
        end
        pkt.distance_raw = {data_byte, bytes_reg[3]};
    end

    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (step) begin
            if (cnt_reg == 3'd4) begin
                for (int i = 0; i < 4; i++) begin
                    bytes_next[i] = 8'd0;
                end
                cnt_next = 3'd0;
            end else begin
                bytes_next[cnt_reg[1:0]] = data_byte;
                cnt_next = cnt_reg + 3'd1;
                // failed start: slide on by one byte
                if (cnt_reg == 3'd1 && !start_ok) begin
                    bytes_next[0] = data_byte;
                    bytes_next[1] = 8'd0;
                    cnt_next      = 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            for (int i = 0; i < 4; i++) begin
                bytes_reg[i] <= 8'd0;
            end
        end else begin
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("byte count beyond a full packet");

endmodule

// ----- design/lspp_table.sv -----
// Per-degree distance table: RAM, clearing sweep after reset, read port.
// Depends on lspp_pkg and lspp_ram.
`timescale 1ns / 1ps

module lspp_table #(
    parameter int DEPTH = lspp_pkg::TABLE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lspp_pkg::tbl_wr_t          wr,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [lspp_pkg::DIST_W-1:0] rd_data,
    output logic                       clearing
);
    import lspp_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DIST_W-1:0] ram_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    assign ram_we    = clearing_reg || wr.en;
    assign ram_waddr = clearing_reg ? clr_addr_reg : wr.addr[AW-1:0];
    assign ram_wdata = clearing_reg ? '0 : wr.data;
    assign clearing  = clearing_reg;

    lspp_ram #(
        .WIDTH(DIST_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    a_no_wr_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !wr.en && !rd_en)
        else $error("table access during clearing sweep");

endmodule

// ----- design/lidar_scan_packet_parser_core.sv -----
// Lidar scan packet parser: packet framing, per-degree distance table, output stage.
// Accepted words pass stage 1 and then the output register; one word per cycle unless m_ready stalls.
// Stage 1 covers the registered table RAM read; the output register holds a result while m_ready is low.
// Reset: synchronous; afterwards a sweep clears all 360 table entries, s_ready low meanwhile.
// Depends on lspp_pkg, lspp_parser, lspp_table, lspp_ram.
`timescale 1ns / 1ps

module lidar_scan_packet_parser_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [7:0]                   s_data_byte,
    input  logic [lspp_pkg::DEG_W-1:0]   s_read_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [lspp_pkg::QUAL_W-1:0]  m_quality,
    output logic [lspp_pkg::ARAW_W-1:0]  m_angle_raw,
    output logic [lspp_pkg::DEG_W-1:0]   m_angle_degree,
    output logic [lspp_pkg::DIST_W-1:0]  m_distance_raw
);
    import lspp_pkg::*;

    logic    scan_enable_reg;
    logic    accept;
    logic    is_read;
    logic    pkt_valid;
    pkt_t    pkt;
    tbl_wr_t tbl_wr;
    logic    rd_en;
    logic    in_range;
    logic [DIST_W-1:0] rd_data;
    logic    clearing;

    // stage 1: decoded word, table read in flight
    logic    s1_valid_reg;
    kind_t   s1_kind_reg;
    pkt_t    s1_pkt_reg;
    logic    s1_oor_reg;
    logic    s1_open;

    // output stage
    logic    m_valid_reg;
    kind_t   m_kind_reg;
    pkt_t    m_pkt_reg;
    logic    m_open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            scan_enable_reg <= cfg_wdata;
        end
    end

    assign m_open  = !m_valid_reg || m_ready;
    assign s1_open = !s1_valid_reg || m_open;
    assign s_ready = !clearing && s1_open;
    assign accept  = s_valid && s_ready;
    assign is_read = (s_mode == MODE_READ);
    assign in_range = (s_read_index < DEG_W'(TABLE_DEPTH));
    assign rd_en   = accept && is_read && in_range;

    lspp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_enable(scan_enable_reg),
        .feed       (accept && !is_read),
        .data_byte  (s_data_byte),
        .pkt_valid  (pkt_valid),
        .pkt        (pkt)
    );

    always_comb begin
        tbl_wr.en   = pkt_valid;
        tbl_wr.addr = pkt.angle_degree[TBL_AW-1:0];
        tbl_wr.data = pkt.distance_raw;
    end

    lspp_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (s_read_index[TBL_AW-1:0]),
        .rd_data (rd_data),
        .clearing(clearing)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_open) begin
            s1_valid_reg <= accept && (is_read || pkt_valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (is_read) begin
                s1_kind_reg              <= KIND_READ;
                s1_pkt_reg.quality       <= '0;
                s1_pkt_reg.angle_raw     <= '0;
                s1_pkt_reg.angle_degree  <= s_read_index;
                s1_pkt_reg.distance_raw  <= '0;
                s1_oor_reg               <= !in_range;
            end else begin
                s1_kind_reg <= KIND_PACKET;
                s1_pkt_reg  <= pkt;
                s1_oor_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_open) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_open && s1_valid_reg) begin
            m_kind_reg             <= s1_kind_reg;
            m_pkt_reg.quality      <= s1_pkt_reg.quality;
            m_pkt_reg.angle_raw    <= s1_pkt_reg.angle_raw;
            m_pkt_reg.angle_degree <= s1_pkt_reg.angle_degree;
            // read reply takes the RAM word unless the index was past the table
            if (s1_kind_reg == KIND_READ) begin
                m_pkt_reg.distance_raw <= s1_oor_reg ? '0 : rd_data;
            end else begin
                m_pkt_reg.distance_raw <= s1_pkt_reg.distance_raw;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_quality      = m_pkt_reg.quality;
    assign m_angle_raw    = m_pkt_reg.angle_raw;
    assign m_angle_degree = m_pkt_reg.angle_degree;
    assign m_distance_raw = m_pkt_reg.distance_raw;

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("word accepted during table clear");

    a_read_reply_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_READ) |->
            (m_pkt_reg.quality == '0 && m_pkt_reg.angle_raw == '0))
        else $error("read reply carries packet fields");

    a_packet_degree: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_PACKET) |->
            (m_pkt_reg.angle_degree < DEG_W'(TABLE_DEPTH)))
        else $error("packet degree not wrapped");

    a_s1_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_open) |=> m_valid_reg)
        else $error("stage 1 word lost");

endmodule
